// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the flow table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRO_ASSERT_NOW(LBL, CLK, RST, A, B) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (A) |-> (B)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRO_ASSERT_NEXT(LBL, CLK, RST, A, B) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (A) |=> (B)) \
    else $error("assertion failed");

`endif

// ----- rtl/lro_pkg.sv -----
// ----------------------------------------------------------------------------
// LRO flow table package
// Types, codes and constants shared by the flow table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lro_pkg;

  localparam int FLOW_SLOTS = 64;
  localparam int IDX_W      = $clog2(FLOW_SLOTS);
  localparam int SLOT_W     = 6;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FLOW_SLOTS - 1);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_OTHER = 2'd1;
  localparam logic [1:0] REQ_TCP   = 2'd2;

  localparam logic [1:0] CFG_AGE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN   = 2'd1;
  localparam logic [1:0] CFG_FLAG_MASK = 2'd2;

  localparam logic [15:0] AGE_LIMIT_RST = 16'd100;
  localparam logic [15:0] MAX_LEN_RST   = 16'd64000;
  localparam logic [7:0]  FLAG_MASK_RST = 8'hef;

  typedef enum logic [2:0] {
    ACT_FWD      = 3'd0,
    ACT_FWD_CSUM = 3'd1,
    ACT_FLUSH    = 3'd2,
    ACT_ABSORB   = 3'd3,
    ACT_NONE     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_exp;
    logic [31:0] ack;
    logic [15:0] len;
    logic [7:0]  flags;
    logic [1:0]  ecn;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic        is_tick;
    logic [31:0] now;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [1:0]  ecn;
    logic [15:0] flen;
    logic [15:0] plen;
  } req_t;

  typedef struct packed {
    logic [15:0] age_limit;
    logic [15:0] max_len;
    logic [7:0]  mask;
  } cfg_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       len;
    logic [7:0]        flags;
    logic [1:0]        ecn;
  } result_t;

  // Everything the head evaluator derives from the slot at the head of the ring.
  typedef struct packed {
    logic        match;
    logic        aged;
    logic        seq_ok;
    logic        over;
    logic        merge_flush;
    logic        new_flag;
    logic [31:0] age;
    entry_t      start_e;
    entry_t      merge_e;
    result_t     flush_r;
    result_t     fwd_r;
    result_t     new_r;
    result_t     mflush_r;
    result_t     mabs_r;
  } eval_t;

endpackage

`default_nettype wire

// ----- rtl/tcp_receive_coalescing_flow_table.sv -----
// ----------------------------------------------------------------------------
// TCP receive coalescing flow table
// Decision engine of a large-receive-offload flow table built as a ring of
// flow cells that rotates past a single head evaluator.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Non-TCP frames and
// TCP frames without payload are answered at once: the forward result shows on
// the next cycle and busy never rises. A tick makes one pass of the table. A
// TCP frame with payload makes one pass to match the table and, unless it is
// forwarded for checksum redo, a second pass to update it. The passes come from
// the ring rotating one slot per cycle through the head evaluator in the scan
// and apply states. Each result is on the result ports for exactly one cycle
// with result_strobe high; the receiver cannot stall, so it must take every
// transfer as it comes. The final result of each request carries last.
`default_nettype none

module tcp_receive_coalescing_flow_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [15:0] wr_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] now_us,
  input  wire logic [31:0] src_ip,
  input  wire logic [31:0] dst_ip,
  input  wire logic [15:0] src_tcp_port,
  input  wire logic [15:0] dst_tcp_port,
  input  wire logic [31:0] seq_number,
  input  wire logic [31:0] ack_number,
  input  wire logic [7:0]  tcp_flag_bits,
  input  wire logic [1:0]  ecn_bits,
  input  wire logic [15:0] frame_len,
  input  wire logic [15:0] payload_len,
  output logic             result_strobe,
  output logic [2:0]       action,
  output logic [lro_pkg::SLOT_W-1:0] slot,
  output logic [15:0]      merged_len,
  output logic [7:0]       merged_flags,
  output logic [1:0]       merged_ecn,
  output logic             last
);
  import lro_pkg::*;

  `include "assert_macros.svh"

  state_t            state, state_next;
  cfg_t              cfg;
  req_t              rq;
  logic [IDX_W-1:0]  idx;
  logic              shift;
  entry_t            ring_q [FLOW_SLOTS];
  entry_t            head_wr;
  eval_t             ev;
  logic              accept;

  logic              hit_v, hit_v_next;
  logic [IDX_W-1:0]  hit_idx, hit_idx_next;
  logic              free_v, free_v_next;
  logic [IDX_W-1:0]  free_idx, free_idx_next;
  logic [IDX_W-1:0]  old_idx, old_idx_next;
  logic [31:0]       old_age, old_age_next;
  logic [IDX_W-1:0]  tgt;

  logic              pend_v;
  result_t           pend;
  logic              pend_load;
  result_t           pend_d;

  logic              emit;
  logic              emit_last;
  result_t           emit_r;
  result_t           out_r;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign shift  = (state == ST_SCAN) || (state == ST_APPLY);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.age_limit <= AGE_LIMIT_RST;
      cfg.max_len   <= MAX_LEN_RST;
      cfg.mask      <= FLAG_MASK_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_AGE_LIMIT: cfg.age_limit <= wr_data;
        CFG_MAX_LEN:   cfg.max_len   <= wr_data;
        CFG_FLAG_MASK: cfg.mask      <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rq.is_tick <= (req_type == REQ_TICK);
      rq.now     <= now_us;
      rq.src_ip  <= src_ip;
      rq.dst_ip  <= dst_ip;
      rq.sport   <= src_tcp_port;
      rq.dport   <= dst_tcp_port;
      rq.seq     <= seq_number;
      rq.ack     <= ack_number;
      rq.flags   <= tcp_flag_bits;
      rq.ecn     <= ecn_bits;
      rq.flen    <= frame_len;
      rq.plen    <= payload_len;
    end
  end

  // The ring: cell k takes from cell k+1, the last cell takes the head's write.
  for (genvar k = 0; k < FLOW_SLOTS; k++) begin : g_ring
    if (k == FLOW_SLOTS - 1) begin : g_tail
      lro_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(head_wr), .q(ring_q[k]));
    end else begin : g_body
      lro_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(ring_q[k+1]),
                       .q(ring_q[k]));
    end
  end

  lro_head u_head (.e(ring_q[0]), .idx(idx), .rq(rq), .cfg(cfg), .ev(ev));

  // Match, free-slot and oldest-flow tracking during the first rotation.
  always_comb begin
    hit_v_next    = hit_v;
    hit_idx_next  = hit_idx;
    free_v_next   = free_v;
    free_idx_next = free_idx;
    old_idx_next  = old_idx;
    old_age_next  = old_age;
    if (!hit_v && ev.match) begin
      hit_v_next   = 1'b1;
      hit_idx_next = idx;
    end
    if (!free_v && !ring_q[0].valid) begin
      free_v_next   = 1'b1;
      free_idx_next = idx;
    end
    if ((idx == '0) || (ev.age > old_age)) begin
      old_idx_next = idx;
      old_age_next = ev.age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      hit_v  <= 1'b0;
      free_v <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      state <= state_next;
      if (shift) begin
        idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      end
      if (accept) begin
        hit_v  <= 1'b0;
        free_v <= 1'b0;
        pend_v <= 1'b0;
      end else if (state == ST_SCAN && !rq.is_tick) begin
        hit_v  <= hit_v_next;
        free_v <= free_v_next;
      end
      if (pend_load) begin
        pend_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && !rq.is_tick) begin
      hit_idx  <= hit_idx_next;
      free_idx <= free_idx_next;
      old_idx  <= old_idx_next;
      old_age  <= old_age_next;
      if (idx == IDX_LAST) begin
        tgt <= hit_v_next ? hit_idx_next : (free_v_next ? free_idx_next : old_idx_next);
      end
    end
    if (pend_load) begin
      pend <= pend_d;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_TICK) begin
            state_next = ST_SCAN;
          end else if (req_type == REQ_TCP && payload_len != 16'd0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (idx == IDX_LAST) begin
          if (rq.is_tick) begin
            state_next = ST_TAIL;
          end else if (!hit_v_next && ev.new_flag) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        if (idx == IDX_LAST) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs, head write-back and pending result.
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_r    = ev.fwd_r;
    pend_load = 1'b0;
    pend_d    = ev.flush_r;
    head_wr   = ring_q[0];
    unique case (state)
      ST_IDLE: begin
        if (accept && req_type != REQ_TICK &&
            (req_type != REQ_TCP || payload_len == 16'd0)) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_r    = '{action: ACT_FWD, slot: '0, len: frame_len,
                        flags: (req_type == REQ_TCP) ? tcp_flag_bits : 8'd0,
                        ecn: (req_type == REQ_TCP) ? ecn_bits : 2'd0};
        end
      end
      ST_SCAN: begin
        if (rq.is_tick) begin
          // Each aged flow pushes out the one before it, so the last one
          // found can still be marked as final.
          if (ev.aged) begin
            head_wr.valid = 1'b0;
            pend_load     = 1'b1;
            pend_d        = ev.flush_r;
            emit          = pend_v;
            emit_r        = pend;
          end
        end else if (idx == IDX_LAST && !hit_v_next && ev.new_flag) begin
          emit         = 1'b1;
          emit_last    = 1'b1;
          emit_r       = ev.fwd_r;
          emit_r.action = ACT_FWD_CSUM;
        end
      end
      ST_APPLY: begin
        if (idx == tgt) begin
          pend_load = 1'b1;
          if (hit_v) begin
            if (!ev.seq_ok) begin
              head_wr.valid = 1'b0;
              emit          = 1'b1;
              emit_r        = ev.flush_r;
              pend_d        = ev.fwd_r;
            end else if (ev.over) begin
              emit   = 1'b1;
              emit_r = ev.flush_r;
              if (ev.new_flag) begin
                head_wr.valid = 1'b0;
                pend_d        = ev.fwd_r;
              end else begin
                head_wr = ev.start_e;
                pend_d  = ev.new_r;
              end
            end else if (ev.merge_flush) begin
              head_wr.valid = 1'b0;
              pend_d        = ev.mflush_r;
            end else begin
              head_wr = ev.merge_e;
              pend_d  = ev.mabs_r;
            end
          end else if (free_v) begin
            head_wr = ev.start_e;
            pend_d  = ev.new_r;
          end else begin
            emit    = 1'b1;
            emit_r  = ev.flush_r;
            head_wr = ev.start_e;
            pend_d  = ev.new_r;
          end
        end
      end
      ST_TAIL: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_r    = pend_v ? pend : '{action: ACT_NONE, slot: '0, len: '0,
                                      flags: '0, ecn: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_r;
      last  <= emit_last;
    end
  end

  assign action       = out_r.action;
  assign slot         = out_r.slot;
  assign merged_len   = out_r.len;
  assign merged_flags = out_r.flags;
  assign merged_ecn   = out_r.ecn;

  `LRO_ASSERT_NEXT(a_tail_final, clk, rst, state == ST_TAIL, result_strobe && last)
  `LRO_ASSERT_NOW(a_idle_aligned, clk, rst, state == ST_IDLE, idx == '0)
  `LRO_ASSERT_NEXT(a_apply_pending, clk, rst, state == ST_APPLY && idx == IDX_LAST, pend_v)

endmodule

`default_nettype wire

// ----- rtl/lro_cell.sv -----
// ----------------------------------------------------------------------------
// LRO flow cell
// One flow slot of the rotating table; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lro_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire lro_pkg::entry_t d,
  output lro_pkg::entry_t      q
);
  import lro_pkg::*;

  logic   valid;
  entry_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  always_comb begin
    q       = data;
    q.valid = valid;
  end

endmodule

`default_nettype wire

// ----- rtl/lro_head.sv -----
// ----------------------------------------------------------------------------
// LRO head evaluator
// Compares the slot at the head of the ring with the current request.
// ----------------------------------------------------------------------------
`default_nettype none

module lro_head (
  input  wire lro_pkg::entry_t        e,
  input  wire logic [lro_pkg::IDX_W-1:0] idx,
  input  wire lro_pkg::req_t          rq,
  input  wire lro_pkg::cfg_t          cfg,
  output lro_pkg::eval_t              ev
);
  import lro_pkg::*;

  logic [16:0]       sum;
  logic [7:0]        mflags;
  logic [1:0]        mecn;
  logic [31:0]       nseq;
  logic [SLOT_W-1:0] sl;

  always_comb begin
    sum    = {1'b0, e.len} + {1'b0, rq.plen};
    mflags = e.flags | rq.flags;
    mecn   = e.ecn | rq.ecn;
    nseq   = rq.seq + {16'd0, rq.plen};
    sl     = SLOT_W'(idx);

    ev.age         = rq.now - e.stamp;
    ev.aged        = e.valid && (ev.age > {16'd0, cfg.age_limit});
    ev.match       = e.valid && (e.src_ip == rq.src_ip) && (e.dst_ip == rq.dst_ip) &&
                     (e.sport == rq.sport) && (e.dport == rq.dport);
    ev.seq_ok      = (e.seq_exp == rq.seq) && (e.ack == rq.ack);
    ev.over        = sum > {1'b0, cfg.max_len};
    ev.merge_flush = (mflags & cfg.mask) != 8'd0;
    ev.new_flag    = (rq.flags & cfg.mask) != 8'd0;

    ev.start_e.valid   = 1'b1;
    ev.start_e.src_ip  = rq.src_ip;
    ev.start_e.dst_ip  = rq.dst_ip;
    ev.start_e.sport   = rq.sport;
    ev.start_e.dport   = rq.dport;
    ev.start_e.seq_exp = nseq;
    ev.start_e.ack     = rq.ack;
    ev.start_e.len     = rq.flen;
    ev.start_e.flags   = rq.flags;
    ev.start_e.ecn     = rq.ecn;
    ev.start_e.stamp   = rq.now;

    ev.merge_e         = e;
    ev.merge_e.len     = sum[15:0];
    ev.merge_e.flags   = mflags;
    ev.merge_e.ecn     = mecn;
    ev.merge_e.seq_exp = nseq;

    ev.flush_r  = '{action: ACT_FLUSH, slot: sl, len: e.len, flags: e.flags, ecn: e.ecn};
    ev.fwd_r    = '{action: ACT_FWD, slot: '0, len: rq.flen, flags: rq.flags, ecn: rq.ecn};
    ev.new_r    = '{action: ACT_ABSORB, slot: sl, len: rq.flen, flags: rq.flags,
                    ecn: rq.ecn};
    ev.mflush_r = '{action: ACT_FLUSH, slot: sl, len: sum[15:0], flags: mflags, ecn: mecn};
    ev.mabs_r   = '{action: ACT_ABSORB, slot: sl, len: sum[15:0], flags: mflags, ecn: mecn};
  end

endmodule

`default_nettype wire

// ----- sim/tcp_receive_coalescing_flow_table_test.sv -----
// ----------------------------------------------------------------------------
// Flow table decision engine testbench
// Walks a directed stimulus table, then streams random flows, ticks and
// foreign frames through the block under several register settings. Every
// result transfer is checked against a local model of the flow table.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_receive_coalescing_flow_table_test;
  import lro_pkg::*;

  typedef struct {
    logic [1:0]  rt;
    logic [31:0] now;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flg;
    logic [1:0]  ecn;
    logic [15:0] flen;
    logic [15:0] plen;
  } frame_hdr_t;

  typedef struct {
    logic [2:0]  act;
    logic [5:0]  slot;
    logic [15:0] len;
    logic [7:0]  flg;
    logic [1:0]  ecn;
    logic        lst;
  } decision_t;

  // A directed row; when typed is set the action of the single expected result is given here.
  typedef struct {
    frame_hdr_t  hdr;
    logic        typed;
    logic [2:0]  act;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [15:0] wr_data;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [31:0] now_us;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_tcp_port;
  logic [15:0] dst_tcp_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [7:0]  tcp_flag_bits;
  logic [1:0]  ecn_bits;
  logic [15:0] frame_len;
  logic [15:0] payload_len;
  logic        result_strobe;
  logic [2:0]  action;
  logic [SLOT_W-1:0] slot;
  logic [15:0] merged_len;
  logic [7:0]  merged_flags;
  logic [1:0]  merged_ecn;
  logic        last;

  tcp_receive_coalescing_flow_table uut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy), .req_type(req_type), .now_us(now_us),
    .src_ip(src_ip), .dst_ip(dst_ip), .src_tcp_port(src_tcp_port),
    .dst_tcp_port(dst_tcp_port), .seq_number(seq_number), .ack_number(ack_number),
    .tcp_flag_bits(tcp_flag_bits), .ecn_bits(ecn_bits), .frame_len(frame_len),
    .payload_len(payload_len), .result_strobe(result_strobe), .action(action),
    .slot(slot), .merged_len(merged_len), .merged_flags(merged_flags),
    .merged_ecn(merged_ecn), .last(last)
  );

  // Local copy of the table and registers.
  logic        tbl_valid [FLOW_SLOTS];
  logic [31:0] tbl_sip   [FLOW_SLOTS];
  logic [31:0] tbl_dip   [FLOW_SLOTS];
  logic [15:0] tbl_sp    [FLOW_SLOTS];
  logic [15:0] tbl_dp    [FLOW_SLOTS];
  logic [31:0] tbl_nseq  [FLOW_SLOTS];
  logic [31:0] tbl_ack   [FLOW_SLOTS];
  logic [15:0] tbl_len   [FLOW_SLOTS];
  logic [7:0]  tbl_flg   [FLOW_SLOTS];
  logic [1:0]  tbl_ecn   [FLOW_SLOTS];
  logic [31:0] tbl_stamp [FLOW_SLOTS];
  logic [15:0] age_limit;
  logic [15:0] max_len;
  logic [7:0]  flag_mask;

  decision_t   pending_decisions[$];
  int          errors;
  int          items_sent;
  int          results_seen;
  int          flushes_seen;

  logic [31:0] pool_sip [96];
  logic [31:0] pool_dip [96];
  logic [15:0] pool_sp  [96];
  logic [15:0] pool_dp  [96];
  logic [31:0] clock_us;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2000000);
    $display("timeout waiting for results");
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
    $display("mismatch on %s: expected %0h, got %0h (result %0d)", what, exp_v, got_v,
             results_seen);
    errors++;
  endtask

  function automatic void emit(input logic [2:0] act, input logic [5:0] s,
                               input logic [15:0] len, input logic [7:0] flg,
                               input logic [1:0] ecn);
    decision_t d;
    d.act = act; d.slot = s; d.len = len; d.flg = flg; d.ecn = ecn; d.lst = 1'b0;
    pending_decisions.push_back(d);
  endfunction

  function automatic void flush_entry(input int s);
    emit(ACT_FLUSH, 6'(s), tbl_len[s], tbl_flg[s], tbl_ecn[s]);
    tbl_valid[s] = 1'b0;
  endfunction

  function automatic void open_flow(input int s, input frame_hdr_t h);
    tbl_valid[s] = 1'b1;
    tbl_sip[s] = h.sip; tbl_dip[s] = h.dip; tbl_sp[s] = h.sp; tbl_dp[s] = h.dp;
    tbl_nseq[s] = h.seq + 32'(h.plen);
    tbl_ack[s] = h.ack; tbl_len[s] = h.flen; tbl_flg[s] = h.flg;
    tbl_ecn[s] = h.ecn; tbl_stamp[s] = h.now;
    emit(ACT_ABSORB, 6'(s), tbl_len[s], tbl_flg[s], tbl_ecn[s]);
  endfunction

  function automatic int find_flow(input frame_hdr_t h);
    for (int i = 0; i < FLOW_SLOTS; i++)
      if (tbl_valid[i] && tbl_sip[i] == h.sip && tbl_dip[i] == h.dip &&
          tbl_sp[i] == h.sp && tbl_dp[i] == h.dp) return i;
    return -1;
  endfunction

  // Works out every result that one accepted header causes.
  function automatic void predict_decisions(input frame_hdr_t h);
    int first;
    int hit;
    int free_s;
    int old;
    logic [16:0] sum;
    first = pending_decisions.size();
    free_s = -1;
    if (h.rt == REQ_TICK) begin
      for (int i = 0; i < FLOW_SLOTS; i++)
        if (tbl_valid[i] && (h.now - tbl_stamp[i]) > 32'(age_limit)) flush_entry(i);
      if (pending_decisions.size() == first) emit(ACT_NONE, 0, 0, 0, 0);
    end else if (h.rt != REQ_TCP) begin
      emit(ACT_FWD, 0, h.flen, 0, 0);
    end else if (h.plen == 0) begin
      emit(ACT_FWD, 0, h.flen, h.flg, h.ecn);
    end else begin
      hit = find_flow(h);
      for (int i = FLOW_SLOTS - 1; i >= 0; i--)
        if (!tbl_valid[i] && (hit < 0 || i < hit)) free_s = i;
      if (hit >= 0) begin
        sum = {1'b0, tbl_len[hit]} + {1'b0, h.plen};
        if (tbl_nseq[hit] != h.seq || tbl_ack[hit] != h.ack) begin
          flush_entry(hit);
          emit(ACT_FWD, 0, h.flen, h.flg, h.ecn);
        end else if (sum > {1'b0, max_len}) begin
          flush_entry(hit);
          if ((h.flg & flag_mask) != 0) emit(ACT_FWD, 0, h.flen, h.flg, h.ecn);
          else open_flow(hit, h);
        end else begin
          tbl_len[hit] = sum[15:0];
          tbl_flg[hit] |= h.flg;
          tbl_ecn[hit] |= h.ecn;
          if ((tbl_flg[hit] & flag_mask) != 0) flush_entry(hit);
          else begin
            tbl_nseq[hit] = h.seq + 32'(h.plen);
            emit(ACT_ABSORB, 6'(hit), tbl_len[hit], tbl_flg[hit], tbl_ecn[hit]);
          end
        end
      end else if ((h.flg & flag_mask) != 0) begin
        emit(ACT_FWD_CSUM, 0, h.flen, h.flg, h.ecn);
      end else begin
        if (free_s < 0) begin
          old = 0;
          for (int i = 1; i < FLOW_SLOTS; i++)
            if ((h.now - tbl_stamp[i]) > (h.now - tbl_stamp[old])) old = i;
          flush_entry(old);
          free_s = old;
        end
        open_flow(free_s, h);
      end
    end
    pending_decisions[pending_decisions.size() - 1].lst = 1'b1;
  endfunction

  // One command transfer: optional idle gap, then hold start until accepted.
  task automatic send_header(input frame_hdr_t h, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= h.rt; now_us <= h.now; src_ip <= h.sip; dst_ip <= h.dip;
    src_tcp_port <= h.sp; dst_tcp_port <= h.dp; seq_number <= h.seq;
    ack_number <= h.ack; tcp_flag_bits <= h.flg; ecn_bits <= h.ecn;
    frame_len <= h.flen; payload_len <= h.plen;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Registers change only once the table has gone quiet.
  task automatic drain_then_write(input logic [15:0] age, input logic [15:0] mlen,
                                  input logic [7:0] mask);
    start <= 1'b0;
    @(posedge clk);
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    wr_en <= 1'b1; wr_index <= CFG_AGE_LIMIT; wr_data <= age;
    @(posedge clk);
    wr_index <= CFG_MAX_LEN; wr_data <= mlen;
    @(posedge clk);
    wr_index <= CFG_FLAG_MASK; wr_data <= {8'h00, mask};
    @(posedge clk);
    wr_en <= 1'b0;
    age_limit = age; max_len = mlen; flag_mask = mask;
  endtask

  function automatic frame_hdr_t random_header();
    frame_hdr_t h;
    int r;
    int k;
    int s;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) clock_us = $urandom;
    else if ($urandom_range(0, 19) == 0) clock_us += $urandom_range(0, 200000);
    else clock_us += $urandom_range(0, 40);
    k = $urandom_range(0, 95);
    h.now = clock_us;
    h.sip = pool_sip[k]; h.dip = pool_dip[k]; h.sp = pool_sp[k]; h.dp = pool_dp[k];
    h.seq = $urandom; h.ack = $urandom;
    h.flg = ($urandom_range(0, 4) != 0) ? 8'h10 : 8'($urandom);
    h.ecn = 2'($urandom);
    h.plen = ($urandom_range(0, 6) != 0) ? 16'($urandom_range(1, 1500)) : 16'($urandom);
    h.flen = h.plen + 16'($urandom_range(40, 80));
    if ($urandom_range(0, 9) == 0) h.flen = 16'($urandom);
    h.rt = REQ_TCP;
    if (r < 8) h.rt = REQ_TICK;
    else if (r < 13) h.rt = ($urandom_range(0, 1) != 0) ? REQ_OTHER : 2'd3;
    else if (r < 18) h.plen = 0;
    else begin
      s = find_flow(h);
      if (s >= 0 && $urandom_range(0, 9) < 8) begin
        h.seq = tbl_nseq[s];
        h.ack = tbl_ack[s];
      end
    end
    return h;
  endfunction

  always @(posedge clk) begin
    decision_t d;
    if (!rst && result_strobe) begin
      results_seen++;
      if (pending_decisions.size() == 0) begin
        $display("result with nothing expected: action %0d slot %0d", action, slot);
        errors++;
      end else begin
        d = pending_decisions.pop_front();
        if (action == ACT_FLUSH) flushes_seen++;
        if (action !== d.act) report_mismatch("action", 16'(d.act), 16'(action));
        if (slot !== d.slot) report_mismatch("slot", 16'(d.slot), 16'(slot));
        if (merged_len !== d.len) report_mismatch("merged_len", d.len, merged_len);
        if (merged_flags !== d.flg)
          report_mismatch("merged_flags", 16'(d.flg), 16'(merged_flags));
        if (merged_ecn !== d.ecn)
          report_mismatch("merged_ecn", 16'(d.ecn), 16'(merged_ecn));
        if (last !== d.lst) report_mismatch("last", 16'(d.lst), 16'(last));
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    frame_hdr_t h;
    decision_t d;
    errors = 0; items_sent = 0; results_seen = 0; flushes_seen = 0;
    rst = 1'b1; wr_en = 1'b0; wr_index = 0; wr_data = 0; start = 1'b0;
    req_type = 0; now_us = 0; src_ip = 0; dst_ip = 0; src_tcp_port = 0;
    dst_tcp_port = 0; seq_number = 0; ack_number = 0; tcp_flag_bits = 0;
    ecn_bits = 0; frame_len = 0; payload_len = 0;
    age_limit = AGE_LIMIT_RST; max_len = MAX_LEN_RST; flag_mask = FLAG_MASK_RST;
    for (int i = 0; i < FLOW_SLOTS; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < 96; i++) begin
      pool_sip[i] = $urandom; pool_dip[i] = $urandom;
      pool_sp[i] = 16'($urandom); pool_dp[i] = 16'($urandom);
    end
    clock_us = 32'hFFFF_FE00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: rt, now, sip, dip, sp, dp, seq, ack, flg, ecn, flen, plen.
    rows.push_back('{'{REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, ACT_NONE});
    rows.push_back('{'{REQ_OTHER, '1, '1, '1, '1, '1, '1, '1, '1, 3, 16'hFFFF, '1},
                     1, ACT_FWD});
    rows.push_back('{'{2'd3, 5, 1, 2, 3, 4, 5, 6, 8'h10, 1, 16'd60, 16'd0}, 1, ACT_FWD});
    rows.push_back('{'{REQ_TCP, 9, 1, 2, 3, 4, 5, 6, 8'hFF, 2, 16'd54, 16'd0},
                     1, ACT_FWD});
    rows.push_back('{'{REQ_TCP, 10, 7, 8, 9, 10, 0, 0, 8'h11, 1, 16'd100, 16'd46},
                     1, ACT_FWD_CSUM});
    // Flow A starts just below the sequence wrap.
    rows.push_back('{'{REQ_TCP, 20, 32'hA, 32'hB, 16'h50, 16'h51, 32'hFFFF_FFF0, 32'h77,
                       8'h10, 1, 16'd86, 16'h20}, 0, 0});
    rows.push_back('{'{REQ_TCP, 21, 32'hA, 32'hB, 16'h50, 16'h51, 32'h10, 32'h77,
                       8'h10, 2, 16'd154, 16'd100}, 0, 0});
    rows.push_back('{'{REQ_TCP, 22, 32'hA, 32'hB, 16'h50, 16'h51, 32'h999, 32'h77,
                       8'h10, 0, 16'd154, 16'd100}, 0, 0});
    rows.push_back('{'{REQ_TCP, 23, 32'hA, 32'hB, 16'h50, 16'h51, 32'h100, 32'h5,
                       8'h10, 0, 16'd154, 16'd100}, 0, 0});
    // A push flag on an append merges and then flushes.
    rows.push_back('{'{REQ_TCP, 24, 32'hA, 32'hB, 16'h50, 16'h51, 32'h164, 32'h5,
                       8'h18, 3, 16'd154, 16'd100}, 0, 0});
    rows.push_back('{'{REQ_TCP, 30, 32'hC, 32'hD, 16'h1, 16'h2, 32'h1000, 32'h9,
                       8'h10, 0, 16'd60054, 16'd60000}, 0, 0});
    // Size overflow restarts the flow; with a flush flag it forwards instead.
    rows.push_back('{'{REQ_TCP, 31, 32'hC, 32'hD, 16'h1, 16'h2, 32'h1000 + 60000, 32'h9,
                       8'h10, 1, 16'd5054, 16'd5000}, 0, 0});
    rows.push_back('{'{REQ_TCP, 32, 32'hC, 32'hD, 16'h1, 16'h2,
                       32'h1000 + 65000, 32'h9, 8'h11, 0, 16'd65535, 16'd65535}, 0, 0});
    rows.push_back('{'{REQ_TCP, 33, '1, '1, '1, '1, '1, '1, 8'h00, 3, '1, 16'd1}, 0, 0});
    rows.push_back('{'{REQ_TICK, 40, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, 0});
    rows.push_back('{'{REQ_TICK, 5000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, 0});
    rows.push_back('{'{REQ_TICK, 5001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, ACT_NONE});

    foreach (rows[i]) begin
      row = rows[i];
      send_header(row.hdr, (i % 3 == 2) ? $urandom_range(1, 30) : 0);
      predict_decisions(row.hdr);
      if (row.typed) begin
        // These cases give a single result that can be written down directly.
        d = pending_decisions.pop_back();
        d.act = row.act; d.slot = 0; d.lst = 1'b1;
        d.len = (row.act == ACT_NONE) ? 16'd0 : row.hdr.flen;
        d.flg = (row.act == ACT_NONE || row.hdr.rt != REQ_TCP) ? 8'd0 : row.hdr.flg;
        d.ecn = (row.act == ACT_NONE || row.hdr.rt != REQ_TCP) ? 2'd0 : row.hdr.ecn;
        pending_decisions.push_back(d);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: drain_then_write(16'd1, 16'd64, 8'hFF);
        1: drain_then_write(16'd65535, 16'd65535, 8'h00);
        2: drain_then_write(16'($urandom_range(1, 65535)), 16'($urandom_range(64, 65535)),
                            8'($urandom));
        default: drain_then_write(AGE_LIMIT_RST, MAX_LEN_RST, FLAG_MASK_RST);
      endcase
      for (int n = 0; n < 80; n++) begin
        h = random_header();
        // The first five headers of every twenty go without gaps to keep the block back to back.
        send_header(h, (n % 20 < 5) ? 0 : pick_gap());
        predict_decisions(h);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    $display("sent %0d headers and ticks, checked %0d results (%0d flushes)",
             items_sent, results_seen, flushes_seen);
    $display("covered four register settings including both extremes");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/lro_pkg.sv
rtl/lro_cell.sv
rtl/lro_head.sv
rtl/tcp_receive_coalescing_flow_table.sv
sim/tcp_receive_coalescing_flow_table_test.sv
